// ===== rtl/srsg_pkg.sv =====
// ----------------------------------------------------------------------------
// srsg_pkg: shared types and constants of the stepper ramp step generator
// Request codes, register indexes, register reset values and port widths.
// ----------------------------------------------------------------------------
package srsg_pkg;

   // Default width of the position and target counters.
   localparam int POS_WIDTH_DEF = 32;

   // Fixed port widths.
   localparam int RATE_WIDTH     = 16;
   localparam int STEPS_WIDTH    = 32;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH = 16;

   // Request kinds carried by req_type.
   typedef enum logic [1:0] {
      REQ_POLL  = 2'd0,
      REQ_TIMER = 2'd1,
      REQ_MOVE  = 2'd2,
      REQ_ZERO  = 2'd3
   } req_kind_type;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ACCEL_INC  = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DECEL_INC  = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MAX_RATE   = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DIR_INVERT = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DRIVE_ACT  = 3'd4;

   // Register values after reset.
   localparam logic [RATE_WIDTH-1:0] ACCEL_INC_RST = 16'd100;
   localparam logic [RATE_WIDTH-1:0] DECEL_INC_RST = 16'd100;
   localparam logic [RATE_WIDTH-1:0] MAX_RATE_RST  = 16'd1000;

   // Largest distance that still matters for the braking limit.
   localparam logic [RATE_WIDTH-1:0] DIST_SAT = 16'hFFFF;

endpackage

// ===== rtl/stepper_ramp_step_generator_unit.sv =====
// ----------------------------------------------------------------------------
// stepper_ramp_step_generator_unit: trapezoidal ramp step generator
//
// Usage: requests (poll, timer expiry, relative move, set zero) enter on the
// req_ channel; every request gives exactly one word on the rsp_ channel with
// the step pulse and direction levels, the timer restart command and rate,
// the running flag, the position and the active-low driver enable.
// Both channels use valid/ready; the csr_ channel writes one register per
// word (index 0..4) and must only be used while no request is in flight.
// A request passes the input register and then the response register, which
// takes the result from the input register when it is free.
// Throughput: one request per cycle while the receiver does not stall; all
// of the rate update (distance, one 16x16 multiply for the braking limit,
// clamps) sits between the input register and the response register.
// When the receiver stalls, the response register holds and the input
// register still takes one more request, after which req_ready drops.
// Reset clears the ramp state, the position and target, both stage valid
// flags and restores the register defaults; no channel is ready in reset.
// ----------------------------------------------------------------------------
module stepper_ramp_step_generator_unit
   import srsg_pkg::*;
#(
   parameter int POS_WIDTH = POS_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // Configuration port.
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata,
   // Request channel.
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_type,
   input  logic signed [STEPS_WIDTH-1:0] req_move_steps,
   // Response channel.
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_step_pulse,
   output logic                      rsp_dir_level,
   output logic                      rsp_timer_start,
   output logic [RATE_WIDTH-1:0]     rsp_timer_rate,
   output logic                      rsp_is_running,
   output logic signed [STEPS_WIDTH-1:0] rsp_step_position,
   output logic                      rsp_enable_n
);

   // Configuration registers.
   logic [RATE_WIDTH-1:0] accel_ff;
   logic [RATE_WIDTH-1:0] decel_ff;
   logic [RATE_WIDTH-1:0] max_rate_ff;
   logic                  dir_invert_ff;
   logic                  drive_ff;

   // Input stage.
   logic                          in_vld_ff;
   req_kind_type                  in_type_ff;
   logic signed [STEPS_WIDTH-1:0] in_steps_ff;

   // Ramp state.
   logic signed [RATE_WIDTH:0] rate_ff, rate_in;
   logic [POS_WIDTH-1:0]       position_ff, position_in;
   logic [POS_WIDTH-1:0]       target_ff, target_in;
   logic                       running_ff, running_in;
   logic                       pulse_ff, pulse_in;
   logic                       dir_ff, dir_in;

   // Response stage.
   logic                          rsp_vld_ff;
   logic                          rsp_pulse_ff;
   logic                          rsp_dir_ff;
   logic                          rsp_tstart_ff;
   logic [RATE_WIDTH-1:0]         rsp_rate_ff;
   logic                          rsp_running_ff;
   logic [STEPS_WIDTH-1:0]        rsp_position_ff;
   logic                          rsp_enable_n_ff;

   // Datapath signals.
   logic                         advance;
   logic                         is_step;
   logic [POS_WIDTH-1:0]         pos_step;
   logic [POS_WIDTH-1:0]         pos_eval;
   logic [POS_WIDTH-1:0]         dist_val;
   logic                         dist_pos;
   logic                         dist_neg;
   logic                         dist_nz;
   logic [POS_WIDTH-1:0]         dist_mag;
   logic [RATE_WIDTH-1:0]        mag_sat;
   logic [2*RATE_WIDTH-1:0]      lim;
   logic                         rate_pos;
   logic                         rate_neg;
   logic [RATE_WIDTH-1:0]        rate_abs;
   logic [RATE_WIDTH:0]          acc_mag;
   logic [RATE_WIDTH:0]          acc_max;
   logic [RATE_WIDTH:0]          acc_lim;
   logic signed [RATE_WIDTH+1:0] brake_up;
   logic signed [RATE_WIDTH+1:0] brake_dn;
   logic signed [RATE_WIDTH:0]   rate_upd;
   logic                         dir_upd;
   logic                         tstart;
   logic [RATE_WIDTH-1:0]        tstart_rate;
   logic [POS_WIDTH+STEPS_WIDTH-1:0] move_wide;
   logic [POS_WIDTH+STEPS_WIDTH-1:0] pos_wide;

   // Handshakes: the input stage moves on when the response register is free.
   assign advance   = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !reset && (!in_vld_ff || advance);
   assign csr_ready = !reset;

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff      <= ACCEL_INC_RST;
         decel_ff      <= DECEL_INC_RST;
         max_rate_ff   <= MAX_RATE_RST;
         dir_invert_ff <= 1'b0;
         drive_ff      <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ACCEL_INC:  accel_ff      <= csr_wdata;
            CSR_DECEL_INC:  decel_ff      <= csr_wdata;
            CSR_MAX_RATE:   max_rate_ff   <= csr_wdata;
            CSR_DIR_INVERT: dir_invert_ff <= csr_wdata[0];
            CSR_DRIVE_ACT:  drive_ff      <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_type_ff  <= req_kind_type'(req_type);
         in_steps_ff <= req_move_steps;
      end
   end

   // Position after a full step; a step at zero rate counts as negative.
   assign rate_pos = !rate_ff[RATE_WIDTH] && (rate_ff != '0);
   assign rate_neg = rate_ff[RATE_WIDTH];
   assign pos_step = rate_pos ? position_ff + POS_WIDTH'(1) : position_ff - POS_WIDTH'(1);
   assign is_step  = (in_type_ff == REQ_TIMER) && running_ff && pulse_ff;
   assign pos_eval = is_step ? pos_step : position_ff;

   // Signed distance to target, wrapping at the position width.
   assign dist_val = target_ff - pos_eval;
   assign dist_neg = dist_val[POS_WIDTH-1];
   assign dist_nz  = (dist_val != '0);
   assign dist_pos = !dist_neg && dist_nz;
   assign dist_mag = dist_neg ? (~dist_val + POS_WIDTH'(1)) : dist_val;

   // Braking limit: saturated distance times the deceleration step.
   assign mag_sat = (dist_mag > POS_WIDTH'(DIST_SAT)) ? DIST_SAT : dist_mag[RATE_WIDTH-1:0];
   assign lim     = mag_sat * decel_ff;

   // Accelerating magnitude, clamped to the maximum rate and the braking limit.
   assign rate_abs = rate_neg ? RATE_WIDTH'(-rate_ff) : rate_ff[RATE_WIDTH-1:0];
   assign acc_mag  = {1'b0, rate_abs} + {1'b0, accel_ff};
   assign acc_max  = (acc_mag > {1'b0, max_rate_ff}) ? {1'b0, max_rate_ff} : acc_mag;
   assign acc_lim  = ({{(RATE_WIDTH-1){1'b0}}, acc_max} > lim) ? lim[RATE_WIDTH:0] : acc_max;

   // Braking on a reversal.
   assign brake_up = {rate_ff[RATE_WIDTH], rate_ff} + {2'b00, decel_ff};
   assign brake_dn = {rate_ff[RATE_WIDTH], rate_ff} - {2'b00, decel_ff};

   // New rate, in priority order of the ramp rules.
   always_comb begin
      priority if (!rate_pos && dist_pos) begin
         rate_upd = brake_up[RATE_WIDTH:0];
      end else if (!rate_neg && dist_neg) begin
         rate_upd = brake_dn[RATE_WIDTH:0];
      end else if (dist_pos) begin
         rate_upd = acc_lim;
      end else if (dist_neg) begin
         rate_upd = ~acc_lim + (RATE_WIDTH+1)'(1);
      end else begin
         rate_upd = rate_ff;
      end
   end

   // Direction follows the sign of the new rate and holds at zero rate.
   always_comb begin
      priority if (!rate_upd[RATE_WIDTH] && (rate_upd != '0)) begin
         dir_upd = dir_invert_ff;
      end else if (rate_upd[RATE_WIDTH]) begin
         dir_upd = !dir_invert_ff;
      end else begin
         dir_upd = dir_ff;
      end
   end

   // Relative move, sign extended or truncated to the position width.
   assign move_wide = {{POS_WIDTH{in_steps_ff[STEPS_WIDTH-1]}}, in_steps_ff};

   // Next state for the request in the input register.
   always_comb begin
      rate_in     = rate_ff;
      position_in = position_ff;
      target_in   = target_ff;
      running_in  = running_ff;
      pulse_in    = pulse_ff;
      dir_in      = dir_ff;
      tstart      = 1'b0;
      unique case (in_type_ff)
         REQ_POLL: begin
            if (drive_ff && !running_ff) begin
               rate_in = rate_upd;
               dir_in  = dir_upd;
               if (dist_nz) begin
                  running_in = 1'b1;
                  pulse_in   = 1'b0;
                  tstart     = 1'b1;
               end
            end
         end
         REQ_TIMER: begin
            if (running_ff) begin
               if (!pulse_ff) begin
                  pulse_in = 1'b1;
                  tstart   = 1'b1;
               end else begin
                  pulse_in    = 1'b0;
                  position_in = pos_step;
                  dir_in      = dir_upd;
                  if (dist_nz) begin
                     rate_in = rate_upd;
                     tstart  = 1'b1;
                  end else begin
                     rate_in    = '0;
                     running_in = 1'b0;
                  end
               end
            end
         end
         REQ_MOVE: begin
            target_in = target_ff + move_wide[POS_WIDTH-1:0];
         end
         REQ_ZERO: begin
            position_in = '0;
            target_in   = '0;
         end
         default: ;
      endcase
   end

   // Timer rate is the magnitude of the rate that the timer is armed with.
   assign tstart_rate = !tstart ? '0 :
                        rate_in[RATE_WIDTH] ? RATE_WIDTH'(-rate_in) :
                        rate_in[RATE_WIDTH-1:0];

   // Position seen on the port: low word, zero extended when narrower.
   assign pos_wide = {{STEPS_WIDTH{1'b0}}, position_in};

   // Ramp state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff     <= '0;
         position_ff <= '0;
         target_ff   <= '0;
         running_ff  <= 1'b0;
         pulse_ff    <= 1'b0;
         dir_ff      <= 1'b0;
      end else if (advance) begin
         rate_ff     <= rate_in;
         position_ff <= position_in;
         target_ff   <= target_in;
         running_ff  <= running_in;
         pulse_ff    <= pulse_in;
         dir_ff      <= dir_in;
      end
   end

   // Response valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_pulse_ff    <= pulse_in;
         rsp_dir_ff      <= dir_in;
         rsp_tstart_ff   <= tstart;
         rsp_rate_ff     <= tstart_rate;
         rsp_running_ff  <= running_in;
         rsp_position_ff <= pos_wide[STEPS_WIDTH-1:0];
         rsp_enable_n_ff <= !drive_ff;
      end
   end

   assign rsp_valid         = rsp_vld_ff;
   assign rsp_step_pulse    = rsp_pulse_ff;
   assign rsp_dir_level     = rsp_dir_ff;
   assign rsp_timer_start   = rsp_tstart_ff;
   assign rsp_timer_rate    = rsp_rate_ff;
   assign rsp_is_running    = rsp_running_ff;
   assign rsp_step_position = rsp_position_ff;
   assign rsp_enable_n      = rsp_enable_n_ff;

endmodule

// ===== rtl/srsg_checker.sv =====
// ----------------------------------------------------------------------------
// srsg_checker: port-level checks of the stepper ramp step generator
// Watches the request and response channels of the top level over time.
// ----------------------------------------------------------------------------
module srsg_checker
   import srsg_pkg::*;
(
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_step_pulse,
   input logic                          rsp_timer_start,
   input logic [RATE_WIDTH-1:0]         rsp_timer_rate,
   input logic                          rsp_is_running,
   input logic signed [STEPS_WIDTH-1:0] rsp_step_position
);

   // A stalled response keeps its word.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_step_position)
         && $stable(rsp_timer_rate) && $stable(rsp_step_pulse))
      else $error("response changed while stalled");

   // A timer restart only happens during a move.
   a_tstart_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_timer_start |-> rsp_is_running)
      else $error("timer restarted while not running");

   // No timer restart means no timer rate.
   a_rate_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_timer_start |-> rsp_timer_rate == '0)
      else $error("timer rate without timer restart");

   // A response appearing on an empty channel comes from a request taken by the input register.
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid ##1 rsp_valid |-> $past(req_valid && req_ready, 2))
      else $error("response without a request");

endmodule

bind stepper_ramp_step_generator_unit srsg_checker u_srsg_checker (.*);

// ===== dv/srsg_ramp_checker.sv =====
// ----------------------------------------------------------------------------
// srsg_ramp_checker: response predictor and scoreboard for the ramp generator
// Watches the csr_, req_ and rsp_ channels of the step generator. It keeps its
// own copy of the registers and of the ramp state, works out the response
// word for every accepted request and compares each accepted response word,
// field by field, with the oldest predicted word.
// ----------------------------------------------------------------------------
module srsg_ramp_checker
   import srsg_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [CSR_IDX_WIDTH-1:0]      csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]     csr_wdata,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [1:0]                    req_type,
   input  logic signed [STEPS_WIDTH-1:0] req_move_steps,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic                          rsp_step_pulse,
   input  logic                          rsp_dir_level,
   input  logic                          rsp_timer_start,
   input  logic [RATE_WIDTH-1:0]         rsp_timer_rate,
   input  logic                          rsp_is_running,
   input  logic signed [STEPS_WIDTH-1:0] rsp_step_position,
   input  logic                          rsp_enable_n,
   output int                            mismatch_count,
   output int                            pending_words
);
   timeunit 1ns;
   timeprecision 1ps;

   // One response word as the block should send it.
   typedef struct packed {
      logic                   step_pulse;
      logic                   dir_level;
      logic                   timer_start;
      logic [RATE_WIDTH-1:0]  timer_rate;
      logic                   is_running;
      logic [STEPS_WIDTH-1:0] step_position;
      logic                   enable_n;
   } ramp_word_type;

   ramp_word_type predicted_words[$];

   // Register copies.
   logic [RATE_WIDTH-1:0]  accel_inc;
   logic [RATE_WIDTH-1:0]  decel_inc;
   logic [RATE_WIDTH-1:0]  rate_cap;
   logic                   dir_inv;
   logic                   drive_on;

   // Ramp state copies.
   logic signed [16:0]     step_rate_q;
   logic [STEPS_WIDTH-1:0] position_q;
   logic [STEPS_WIDTH-1:0] target_q;
   logic                   running_q;
   logic                   pulse_q;
   logic                   dir_q;

   // Brake, accelerate or clamp the rate toward the target and update the
   // direction line. Returns the signed distance that was used.
   function automatic logic signed [STEPS_WIDTH-1:0] ramp_update();
      logic signed [STEPS_WIDTH-1:0] dist_val;
      longint dist_abs;
      longint brake_cap;
      longint rate;
      longint acc;
      longint dec;
      longint cap;
      dist_val = target_q - position_q;
      acc  = longint'(accel_inc);
      dec  = longint'(decel_inc);
      cap  = longint'(rate_cap);
      rate = longint'(step_rate_q);
      dist_abs = (dist_val < 0) ? -longint'(dist_val) : longint'(dist_val);
      if (dist_abs > 65536) begin
         dist_abs = 65536;
      end
      brake_cap = dist_abs * dec;

      if (rate <= 0 && dist_val > 0) begin
         rate = rate + dec;
      end else if (rate >= 0 && dist_val < 0) begin
         rate = rate - dec;
      end else if (dist_val > 0) begin
         rate = rate + acc;
         if (rate > cap) rate = cap;
         if (rate > brake_cap) rate = brake_cap;
      end else if (dist_val < 0) begin
         rate = rate - acc;
         if (rate < -cap) rate = -cap;
         if (rate < -brake_cap) rate = -brake_cap;
      end
      step_rate_q = rate[16:0];

      // A zero rate leaves the direction line where it was.
      if (step_rate_q > 0) begin
         dir_q = dir_inv;
      end else if (step_rate_q < 0) begin
         dir_q = !dir_inv;
      end
      return dist_val;
   endfunction

   function automatic void check_field(string fname, logic [STEPS_WIDTH-1:0] want,
                                       logic [STEPS_WIDTH-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
         mismatch_count++;
      end
   endfunction

   // Register writes, request prediction and response comparison, all taken
   // at the clock edge at which the handshake completes.
   always @(posedge clock) begin : ramp_monitor
      ramp_word_type want_w;
      logic          tstart;
      longint        rate_abs;
      if (reset) begin
         accel_inc      = ACCEL_INC_RST;
         decel_inc      = DECEL_INC_RST;
         rate_cap       = MAX_RATE_RST;
         dir_inv        = 1'b0;
         drive_on       = 1'b0;
         step_rate_q    = '0;
         position_q     = '0;
         target_q       = '0;
         running_q      = 1'b0;
         pulse_q        = 1'b0;
         dir_q          = 1'b0;
         mismatch_count = 0;
         predicted_words.delete();
         pending_words <= 0;
      end else begin
         // Register write.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ACCEL_INC:  accel_inc = csr_wdata;
               CSR_DECEL_INC:  decel_inc = csr_wdata;
               CSR_MAX_RATE:   rate_cap  = csr_wdata;
               CSR_DIR_INVERT: dir_inv   = csr_wdata[0];
               CSR_DRIVE_ACT:  drive_on  = csr_wdata[0];
               default: ;
            endcase
         end

         // Response word against the oldest prediction.
         if (rsp_valid && rsp_ready) begin
            if (predicted_words.size() == 0) begin
               $error("response word with no request waiting");
               mismatch_count++;
            end else begin
               want_w = predicted_words.pop_front();
               check_field("step_pulse", want_w.step_pulse, rsp_step_pulse);
               check_field("dir_level", want_w.dir_level, rsp_dir_level);
               check_field("timer_start", want_w.timer_start, rsp_timer_start);
               check_field("timer_rate", want_w.timer_rate, rsp_timer_rate);
               check_field("is_running", want_w.is_running, rsp_is_running);
               check_field("step_position", want_w.step_position, rsp_step_position);
               check_field("enable_n", want_w.enable_n, rsp_enable_n);
            end
         end

         // Request: advance the ramp state and predict its word.
         if (req_valid && req_ready) begin
            tstart = 1'b0;
            case (req_type)
               REQ_POLL: begin
                  // Ignored while running or with the drive off.
                  if (drive_on && !running_q) begin
                     if (ramp_update() != 0) begin
                        running_q = 1'b1;
                        pulse_q   = 1'b0;
                        tstart    = 1'b1;
                     end
                  end
               end
               REQ_TIMER: begin
                  // No timer is armed while idle.
                  if (running_q) begin
                     if (!pulse_q) begin
                        pulse_q = 1'b1;
                        tstart  = 1'b1;
                     end else begin
                        // Falling edge ends a full step; zero rate steps down.
                        pulse_q = 1'b0;
                        if (step_rate_q > 0) begin
                           position_q = position_q + 1'b1;
                        end else begin
                           position_q = position_q - 1'b1;
                        end
                        if (ramp_update() != 0) begin
                           tstart = 1'b1;
                        end else begin
                           step_rate_q = '0;
                           running_q   = 1'b0;
                        end
                     end
                  end
               end
               REQ_MOVE: begin
                  target_q = target_q + req_move_steps;
               end
               default: begin
                  position_q = '0;
                  target_q   = '0;
               end
            endcase
            rate_abs = (step_rate_q < 0) ? -longint'(step_rate_q) : longint'(step_rate_q);
            want_w.step_pulse    = pulse_q;
            want_w.dir_level     = dir_q;
            want_w.timer_start   = tstart;
            want_w.timer_rate    = tstart ? rate_abs[RATE_WIDTH-1:0] : '0;
            want_w.is_running    = running_q;
            want_w.step_position = position_q;
            want_w.enable_n      = !drive_on;
            predicted_words.push_back(want_w);
         end
         pending_words <= predicted_words.size();
      end
   end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench top of the stepper ramp step generator
// Drives reset, register settings and request words, with random sender gaps
// and receiver stalls, and gives the verdict. A directed opening covers the
// field extremes and the ignored and special requests; random move profiles
// and noise follow under several register settings. Checking is done by the
// checker instantiated beside the block.
// ----------------------------------------------------------------------------
module tb_top
   import srsg_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_HALF  = 2;
   localparam int RESET_LEN = 11;
   localparam int DRAIN_GAP = 4;
   localparam int RUN_LIMIT = 400000;

   logic                          clock          = 1'b0;
   logic                          reset          = 1'b1;
   logic                          csr_valid      = 1'b0;
   logic                          csr_ready;
   logic [CSR_IDX_WIDTH-1:0]      csr_index      = '0;
   logic [CSR_DATA_WIDTH-1:0]     csr_wdata      = '0;
   logic                          req_valid      = 1'b0;
   logic                          req_ready;
   logic [1:0]                    req_type       = REQ_POLL;
   logic signed [STEPS_WIDTH-1:0] req_move_steps = '0;
   logic                          rsp_valid;
   logic                          rsp_ready      = 1'b0;
   logic                          rsp_step_pulse;
   logic                          rsp_dir_level;
   logic                          rsp_timer_start;
   logic [RATE_WIDTH-1:0]         rsp_timer_rate;
   logic                          rsp_is_running;
   logic signed [STEPS_WIDTH-1:0] rsp_step_position;
   logic                          rsp_enable_n;

   int          mismatch_total;
   int          words_pending;
   int unsigned src_idle_pct = 0;
   int unsigned rcv_idle_pct = 0;
   int unsigned cycle_count  = 0;

   stepper_ramp_step_generator_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_move_steps    (req_move_steps),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_step_pulse    (rsp_step_pulse),
      .rsp_dir_level     (rsp_dir_level),
      .rsp_timer_start   (rsp_timer_start),
      .rsp_timer_rate    (rsp_timer_rate),
      .rsp_is_running    (rsp_is_running),
      .rsp_step_position (rsp_step_position),
      .rsp_enable_n      (rsp_enable_n)
   );

   srsg_ramp_checker u_ramp_check (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_move_steps    (req_move_steps),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_step_pulse    (rsp_step_pulse),
      .rsp_dir_level     (rsp_dir_level),
      .rsp_timer_start   (rsp_timer_start),
      .rsp_timer_rate    (rsp_timer_rate),
      .rsp_is_running    (rsp_is_running),
      .rsp_step_position (rsp_step_position),
      .rsp_enable_n      (rsp_enable_n),
      .mismatch_count    (mismatch_total),
      .pending_words     (words_pending)
   );

   // Clock, 4 ns period.
   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // Receiver: stall at random at the current rate.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // Offer one request word, after an optional random gap, and wait for it
   // to be taken. Valid stays high between back-to-back words.
   task automatic send_request(input req_kind_type kind, input logic [STEPS_WIDTH-1:0] steps);
      if ($urandom_range(0, 99) < src_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < src_idle_pct);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_move_steps <= steps;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop offering requests and wait until every predicted word has arrived.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (words_pending != 0);
      repeat (DRAIN_GAP) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Drain, then write all registers; the unused indexes get random data.
   task automatic apply_setting(input logic [RATE_WIDTH-1:0] acc,
                                input logic [RATE_WIDTH-1:0] dec,
                                input logic [RATE_WIDTH-1:0] cap,
                                input logic inv, input logic act);
      int k;
      wait_drained();
      write_reg(CSR_ACCEL_INC, acc);
      write_reg(CSR_DECEL_INC, dec);
      write_reg(CSR_MAX_RATE, cap);
      write_reg(CSR_DIR_INVERT, {15'($urandom), inv});
      write_reg(CSR_DRIVE_ACT, {15'($urandom), act});
      for (k = int'(CSR_DRIVE_ACT) + 1; k < (1 << CSR_IDX_WIDTH); k++) begin
         write_reg(CSR_IDX_WIDTH'(k), CSR_DATA_WIDTH'($urandom));
      end
      csr_valid <= 1'b0;
   endtask

   // Mostly move profiles (relative move, poll, then the timer expiries of
   // the move with the odd disturbance), the rest single random words.
   task automatic run_random(input int unsigned n_items);
      int unsigned sent;
      int unsigned steps_abs;
      int unsigned n_timer;
      int unsigned k;
      logic [STEPS_WIDTH-1:0] delta;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 99) < 75) begin
            steps_abs = $urandom_range(1, 40);
            delta = STEPS_WIDTH'(steps_abs);
            if ($urandom_range(0, 1) == 1) delta = -delta;
            send_request(REQ_MOVE, delta);
            send_request(REQ_POLL, STEPS_WIDTH'($urandom));
            n_timer = 2 * steps_abs + $urandom_range(0, 3);
            for (k = 0; k < n_timer; k++) begin
               // Retarget, zero or poll in the middle of the move.
               if ($urandom_range(0, 99) < 5) begin
                  case ($urandom_range(0, 2))
                     0: begin
                        delta = STEPS_WIDTH'($urandom_range(1, 12));
                        if ($urandom_range(0, 1) == 1) delta = -delta;
                        send_request(REQ_MOVE, delta);
                     end
                     1: send_request(REQ_ZERO, STEPS_WIDTH'($urandom));
                     default: send_request(REQ_POLL, STEPS_WIDTH'($urandom));
                  endcase
               end
               send_request(REQ_TIMER, STEPS_WIDTH'($urandom));
            end
            sent += 2 + n_timer;
         end else begin
            send_request(req_kind_type'($urandom_range(0, 3)), STEPS_WIDTH'($urandom));
            sent++;
         end
      end
   endtask

   // Main sequence.
   initial begin : stimulus
      int unsigned phase;
      int unsigned phase_items[6];
      phase_items = '{110, 120, 100, 60, 150, 160};
      repeat (RESET_LEN) @(posedge clock);
      reset <= 1'b0;
      src_idle_pct = 31;
      rcv_idle_pct = 45;

      // Drive off: poll and timer are ignored, the move field takes both extremes.
      send_request(REQ_POLL, '0);
      send_request(REQ_TIMER, '0);
      send_request(REQ_MOVE, 32'h7FFF_FFFF);
      send_request(REQ_MOVE, 32'h8000_0000);
      send_request(REQ_ZERO, 32'hFFFF_FFFF);

      // Drive on: poll at zero distance, a short move, ignored poll while
      // running, a reversal, and a set zero in the middle of the move.
      apply_setting(ACCEL_INC_RST, DECEL_INC_RST, MAX_RATE_RST, 1'b0, 1'b1);
      send_request(REQ_POLL, '0);
      send_request(REQ_MOVE, 32'd3);
      send_request(REQ_POLL, '0);
      send_request(REQ_POLL, '0);
      repeat (2) send_request(REQ_TIMER, '0);
      send_request(REQ_MOVE, STEPS_WIDTH'(-6));
      repeat (6) send_request(REQ_TIMER, '0);
      send_request(REQ_ZERO, '0);
      repeat (4) send_request(REQ_TIMER, '0);

      // Random phases under changing settings and idling.
      for (phase = 0; phase < 6; phase++) begin
         case (phase / 2)
            0: begin
               src_idle_pct = 31;
               rcv_idle_pct = 45;
            end
            1: begin
               src_idle_pct = 45;
               rcv_idle_pct = 31;
            end
            default: begin
               src_idle_pct = 0;
               rcv_idle_pct = 0;
            end
         endcase
         case (phase)
            0: ;
            1: apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
            // Zero rates: every step taken at rate zero goes down.
            2: apply_setting('0, '0, '0, 1'b0, 1'b1);
            // Drive off while a move may still be running.
            3: apply_setting(RATE_WIDTH'($urandom_range(1, 400)),
                             RATE_WIDTH'($urandom_range(1, 400)),
                             RATE_WIDTH'($urandom_range(50, 4000)),
                             1'($urandom_range(0, 1)), 1'b0);
            default: apply_setting(RATE_WIDTH'($urandom_range(1, 400)),
                                   RATE_WIDTH'($urandom_range(1, 400)),
                                   RATE_WIDTH'($urandom_range(50, 4000)),
                                   1'($urandom_range(0, 1)), 1'b1);
         endcase
         run_random(phase_items[phase]);
      end

      wait_drained();
      if (mismatch_total == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
